// ----- hdl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the sextet-to-ASCII mapping of the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // ASCII code of the padding character '='.
  localparam logic [7:0] PAD_CHAR = 8'd61;

  // Bytes held before a group is formed, at most two.
  localparam logic [1:0] HELD_MAX = 2'd2;

  // One 3-byte group as it travels from the front end to the back end.
  typedef struct packed {
    logic [23:0] bits;   // zero-filled group, oldest byte in the top bits
    logic [1:0]  held;   // message bytes in the group minus one
    logic        last;   // group ends the message
  } group_t;

  // Map a sextet to its character of the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] sx);
    logic [7:0] s8;
    s8 = {2'b00, sx};
    if (sx < 6'd26) begin
      sextet_char = 8'd65 + s8;
    end else if (sx < 6'd52) begin
      sextet_char = 8'd71 + s8;        // 'a' - 26
    end else if (sx < 6'd62) begin
      sextet_char = s8 - 8'd4;         // '0' - 52
    end else if (sx == 6'd62) begin
      sextet_char = 8'd43;             // '+'
    end else begin
      sextet_char = 8'd47;             // '/'
    end
  endfunction

endpackage

// ----- hdl/b64e_front.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Collects message bytes into 3-byte groups and hands finished groups on.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output b64e_pkg::group_t  q_data
);

  logic [15:0] pending_r, pending_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        accept;
  logic        close_group;

  // A word is taken whenever the group queue has room.
  assign accept      = in_push && !q_full;
  assign close_group = (held_r >= b64e_pkg::HELD_MAX) || in_last_byte;
  assign q_push      = accept && close_group;

  // Build the zero-filled group from the held bytes and the new byte.
  always_comb begin
    q_data.held = (held_r >= b64e_pkg::HELD_MAX) ? b64e_pkg::HELD_MAX : held_r;
    q_data.last = in_last_byte;
    unique case (q_data.held)
      2'd0:    q_data.bits = {in_data_byte, 16'h0000};
      2'd1:    q_data.bits = {pending_r[7:0], in_data_byte, 8'h00};
      default: q_data.bits = {pending_r, in_data_byte};
    endcase
  end

  // Hold bytes until the group closes.
  always_comb begin
    pending_nxt = pending_r;
    held_nxt    = held_r;
    if (accept) begin
      if (close_group) begin
        pending_nxt = 16'h0000;
        held_nxt    = 2'd0;
      end else begin
        pending_nxt = {pending_r[7:0], in_data_byte};
        held_nxt    = held_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 16'h0000;
      held_r    <= 2'd0;
    end else begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

// ----- hdl/b64e_fifo.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Short first-in first-out queue of groups between front and back end.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::group_t  din,
  input  logic              pop,
  output b64e_pkg::group_t  dout,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::group_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/b64e_back.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Expands one group into four characters into an output register, one per cycle while that register is drained.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  b64e_pkg::group_t  q_data,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [7:0]        out_char,
  output logic              out_last
);

  b64e_pkg::group_t grp_r, grp_nxt;
  logic       grp_valid_r, grp_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load_ok;
  logic       emit;
  logic [5:0] sextet;
  logic       is_pad;

  // The output register takes a new word when it is empty or being drained.
  assign load_ok = !out_valid_r || out_pop;
  assign emit    = load_ok && grp_valid_r;
  assign q_pop   = !q_empty && (!grp_valid_r || (emit && idx_r == 2'd3));

  // Select the sextet of the current character, most significant first.
  always_comb begin
    unique case (idx_r)
      2'd0:    sextet = grp_r.bits[23:18];
      2'd1:    sextet = grp_r.bits[17:12];
      2'd2:    sextet = grp_r.bits[11:6];
      default: sextet = grp_r.bits[5:0];
    endcase
  end

  // Characters past the held bytes plus one are padding.
  assign is_pad = {1'b0, idx_r} > ({1'b0, grp_r.held} + 3'd1);

  always_comb begin
    grp_nxt       = grp_r;
    grp_valid_nxt = grp_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
      out_last_nxt  = grp_r.last && (idx_r == 2'd3);
      idx_nxt       = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        grp_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      grp_nxt       = q_data;
      grp_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    grp_r      <= grp_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ----- hdl/base64_stream_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Base64 stream encoder core
// Encodes a byte stream into standard-alphabet Base64 characters with padding.
// ----------------------------------------------------------------------------
// A byte is taken whenever in_full is low. in_full follows the group
// queue (GROUP_QUEUE_DEPTH groups), so while that queue is full every
// byte waits, including bytes that only fill a group. Characters leave
// one per cycle while out_pop drains them, through the single output
// register, so a long message is limited by that one character port. The
// last character of a message, after any '=' padding, carries out_last.
module base64_stream_encoder_core #(
  parameter int GROUP_QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_last
);

  b64e_pkg::group_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_empty;

  assign in_full = q_full;

  // Group assembly.
  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // Queue between the two halves.
  b64e_fifo #(
    .DEPTH (GROUP_QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_wdata),
    .pop   (q_pop),
    .dout  (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Character generation.
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ----- hdl/b64e_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 encoder port checker
// Concurrent checks on the encoder's ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic       out_last
);

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // Reset leaves room for input.
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char) && $stable(out_last)))
    else $error("waiting result changed before it was taken");

  // Every character shown is from the alphabet or padding.
  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_char >= 8'd65 && out_char <= 8'd90) ||
                    (out_char >= 8'd97 && out_char <= 8'd122) ||
                    (out_char >= 8'd48 && out_char <= 8'd57) ||
                    out_char == 8'd43 || out_char == 8'd47 || out_char == 8'd61))
    else $error("illegal output character");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_char     (out_char),
  .out_last     (out_last)
);
